/* design/mcad_pkg.sv */
// Shared types, constants and helpers for the magnetic cover attach/detach detector.
// Depends on nothing; imported by mcad_step and the top level.
package mcad_pkg;

  localparam int SampleWidth = 16;
  localparam int AxisCount   = 3;
  localparam int AxisIdxW    = (AxisCount > 1) ? $clog2(AxisCount) : 1;
  localparam int ThrWidth    = 16;
  localparam int LevelWidth  = 15;
  localparam int CfgIdxWidth = 2;
  localparam int CfgDataWidth = 16;
  localparam int WideWidth   = SampleWidth + 2;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic [AxisCount-1:0][SampleWidth-1:0] vec_t;
  typedef logic [AxisIdxW-1:0] axis_idx_t;
  typedef logic signed [WideWidth-1:0] wide_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgAxisChoice     = 2'd0,
    CfgThreshold      = 2'd1,
    CfgDetachMargin   = 2'd2,
    CfgSatLevel       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                  kind;
    sample_t               field_x;
    sample_t               field_y;
    sample_t               field_z;
    logic                  saturated;
    logic [1:0]            report_axis;
  } in_item_t;

  typedef struct packed {
    logic    cover_closed;
    logic    attach_passed;
    logic    detach_passed;
    logic    test_running;
    sample_t baseline_value;
    sample_t attach_value;
    sample_t extremum_value;
    sample_t detach_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                 axis_choice;
    logic signed [ThrWidth-1:0] signed_threshold;
    logic [LevelWidth-1:0]      pullback_gap;
    logic [LevelWidth-1:0]      saturation_level;
  } cfg_t;

  typedef struct packed {
    logic                     baseline_set;
    logic                     test_flag;
    axis_idx_t                latched_axis;
    logic [SampleWidth:0]     latched_threshold;
    vec_t                     baseline_vec;
    vec_t                     attach_vec;
    vec_t                     extremum_vec;
    vec_t                     detach_vec;
    sample_t                  open_max;
    sample_t                  open_min;
    logic signed [SampleWidth:0] last_excursion;
    logic                     closed_flag;
    logic                     attach_ok;
    logic                     detach_ok;
  } state_t;

  // Saturate an out-of-range axis code to the last axis.
  function automatic axis_idx_t clamp_axis(input logic [1:0] a);
    return (int'(a) >= AxisCount) ? axis_idx_t'(AxisCount - 1) : axis_idx_t'(a);
  endfunction

  function automatic wide_t abs_wide(input wide_t x);
    return (x < 0) ? -x : x;
  endfunction

endpackage

/* design/mcad_step.sv */
// Next-state and result logic for one transaction of the cover detector.
// Purely combinational; depends on mcad_pkg.
module mcad_step (
  input  mcad_pkg::state_t   cur_i,
  input  mcad_pkg::cfg_t     cfg_i,
  input  mcad_pkg::in_item_t item_i,
  output mcad_pkg::state_t   nxt_o,
  output mcad_pkg::out_item_t res_o
);
  import mcad_pkg::*;

  vec_t      m;
  vec_t      ms;
  axis_idx_t a;
  axis_idx_t base_axis;
  axis_idx_t r;
  wide_t     v, b, mx, mn, dv, dmx, dmn, thr, thr_in, thr_mag;
  wide_t     msa, ea, ea_new, cd, marg;
  sample_t   lvl;
  logic      up, ext_take, det_take, det_done;

  assign m[0] = item_i.field_x;
  assign m[1] = item_i.field_y;
  assign m[2] = item_i.field_z;

  assign a         = cur_i.latched_axis;
  assign base_axis = clamp_axis(cfg_i.axis_choice);
  assign r         = clamp_axis(item_i.report_axis);

  // Open-cover arithmetic
  assign v   = wide_t'($signed(m[a]));
  assign b   = wide_t'($signed(cur_i.baseline_vec[a]));
  assign mx  = wide_t'(cur_i.open_max);
  assign mn  = wide_t'(cur_i.open_min);
  assign dv  = v - b;
  assign dmx = mx - b;
  assign dmn = mn - b;
  assign thr = wide_t'({1'b0, cur_i.latched_threshold});
  assign thr_in  = wide_t'(cfg_i.signed_threshold);
  assign thr_mag = abs_wide(thr_in);

  // Closed-cover arithmetic; a saturated sample reads as the level on every axis
  assign up  = cur_i.last_excursion > 0;
  assign lvl = sample_t'(cfg_i.saturation_level);
  always_comb begin
    for (int i = 0; i < AxisCount; i++) begin
      if (item_i.saturated) begin
        ms[i] = up ? lvl : -lvl;
      end else begin
        ms[i] = m[i];
      end
    end
  end
  assign msa      = wide_t'($signed(ms[a]));
  assign ea       = wide_t'($signed(cur_i.extremum_vec[a]));
  assign ext_take = up ? (msa > ea) : (msa < ea);
  assign ea_new   = ext_take ? msa : ea;
  assign cd       = msa - ea_new;
  assign marg     = wide_t'({1'b0, cfg_i.pullback_gap});
  assign det_take = up ? (msa < ea_new - marg) : (msa > ea_new + marg);
  assign det_done = up ? (cd < -thr) : (cd > thr);

  always_comb begin
    nxt_o = cur_i;
    priority if (!item_i.kind) begin
      nxt_o.test_flag    = 1'b1;
      nxt_o.baseline_set = 1'b0;
    end else if (cur_i.test_flag) begin
      priority if (!cur_i.baseline_set) begin
        // Baseline sample: the open pass on it sees zero deviation, so nothing more
        nxt_o.baseline_vec      = m;
        nxt_o.attach_vec        = m;
        nxt_o.extremum_vec      = '0;
        nxt_o.detach_vec        = '0;
        nxt_o.latched_axis      = base_axis;
        nxt_o.latched_threshold = thr_mag[SampleWidth:0];
        nxt_o.open_max          = sample_t'(m[base_axis]);
        nxt_o.open_min          = sample_t'(m[base_axis]);
        nxt_o.last_excursion    = '0;
        nxt_o.closed_flag       = 1'b0;
        nxt_o.attach_ok         = 1'b0;
        nxt_o.detach_ok         = 1'b0;
        nxt_o.baseline_set      = 1'b1;
      end else if (!cur_i.closed_flag) begin
        if (v > mx) begin
          nxt_o.open_max = sample_t'(m[a]);
          if (abs_wide(dv) > abs_wide(dmn)) begin
            nxt_o.attach_vec = m;
          end
        end else if (v < mn) begin
          nxt_o.open_min = sample_t'(m[a]);
          if (abs_wide(dmx) < abs_wide(dv)) begin
            nxt_o.attach_vec = m;
          end
        end
        nxt_o.last_excursion = dv[SampleWidth:0];
        if (abs_wide(dv) > thr) begin
          nxt_o.closed_flag  = 1'b1;
          nxt_o.attach_ok    = 1'b1;
          nxt_o.attach_vec   = m;
          nxt_o.extremum_vec = m;
        end
      end else begin
        if (ext_take) begin
          nxt_o.extremum_vec = ms;
          nxt_o.detach_vec   = '0;
        end
        if (det_take) begin
          nxt_o.detach_vec = ms;
        end
        if (det_done) begin
          nxt_o.closed_flag = 1'b0;
          nxt_o.detach_ok   = 1'b1;
          nxt_o.test_flag   = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res_o.cover_closed   = nxt_o.closed_flag;
    res_o.attach_passed  = nxt_o.attach_ok;
    res_o.detach_passed  = nxt_o.detach_ok;
    res_o.test_running   = nxt_o.test_flag;
    res_o.baseline_value = sample_t'(nxt_o.baseline_vec[r]);
    res_o.attach_value   = sample_t'(nxt_o.attach_vec[r]);
    res_o.extremum_value = sample_t'(nxt_o.extremum_vec[r]);
    res_o.detach_value   = sample_t'(nxt_o.detach_vec[r]);
  end

endmodule

/* design/magnetic_cover_attach_detach_detector_unit.sv */
// Top level of the magnetic cover attach/detach detector.
// Depends on mcad_pkg and mcad_step.
//
// The unit runs a factory attach/detach test on a stream of three-axis
// magnetometer transactions. A restart transaction arms the test; the next
// sample becomes the baseline and latches the watched axis and the absolute
// threshold from the configuration registers. While the cover reads open the
// unit follows the max and min on that axis and declares attach once the
// deviation from the baseline passes the threshold; while closed it follows
// the extremum in the attach direction (a saturated sample reads as plus or
// minus the saturation level) and declares detach, ending the test, once the
// pull-back passes the threshold. Every input transaction yields exactly one
// result transaction carrying the flags and the vectors on the requested axis.
// The whole step is evaluated between the input port and the result
// register, and a new transaction is taken every cycle while the result
// register is empty or being drained. The result is valid in the cycle after
// acceptance. Configuration is a plain write port and takes effect for the
// next transaction.
module magnetic_cover_attach_detach_detector_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mcad_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [mcad_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mcad_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mcad_pkg::out_item_t                 out_data_o
);
  import mcad_pkg::*;

  state_t    state_q, state_d;
  cfg_t      cfg_q;
  out_item_t out_q, res;
  logic      out_valid_q;
  logic      in_fire;

  // Take a transaction whenever the result register is free or being emptied
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  mcad_step u_step (
    .cur_i  (state_q),
    .cfg_i  (cfg_q),
    .item_i (in_data_i),
    .nxt_o  (state_d),
    .res_o  (res)
  );

  // Configuration registers, reset to their documented defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_choice      <= 2'd0;
      cfg_q.signed_threshold <= 16'sd700;
      cfg_q.pullback_gap     <= 15'd100;
      cfg_q.saturation_level <= 15'd4900;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAxisChoice:   cfg_q.axis_choice      <= cfg_data_i[1:0];
        CfgThreshold:    cfg_q.signed_threshold <= $signed(cfg_data_i[ThrWidth-1:0]);
        CfgDetachMargin: cfg_q.pullback_gap     <= cfg_data_i[LevelWidth-1:0];
        CfgSatLevel:     cfg_q.saturation_level <= cfg_data_i[LevelWidth-1:0];
      endcase
    end
  end

  // Detector state: advance only on an accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Result valid: set on acceptance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: hold until replaced by the next accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted transaction produced no result");

  a_detach_after_attach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.detach_ok |-> state_q.attach_ok)
    else $error("detach pass without attach pass");

  a_closed_after_attach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.closed_flag |-> state_q.attach_ok)
    else $error("cover closed without attach pass");

  a_detach_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.detach_ok |-> !state_q.closed_flag)
    else $error("cover still closed after detach pass");

endmodule

/* verif/tb_magnetic_cover_attach_detach_detector_unit.sv */
// Self-checking testbench for the magnetic cover attach/detach detector unit.
// Depends on mcad_pkg and magnetic_cover_attach_detach_detector_unit; reads no files.
// A queue-fed driver, a stalling receiver and an in-bench detector model check every result.
`timescale 1ns / 1ps

module tb_magnetic_cover_attach_detach_detector_unit;
  import mcad_pkg::*;

  localparam int  LIMIT_CYCLES  = 400000;
  localparam int  PHASE_ITEMS   = 194;
  localparam int  SETTING_COUNT = 8;
  localparam bit  KIND_RESTART  = 1'b0;
  localparam bit  KIND_SAMPLE   = 1'b1;
  localparam int  SAMPLE_MAX    = 32767;
  localparam int  SAMPLE_MIN    = -32768;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_HELD
  } ready_mode_e;

  // Clock, reset and the pins of the unit; every input is known from time zero.
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_item_t                in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_item_t               out_data;

  // Samples waiting for the driver and detector reports still owed by the unit.
  in_item_t  queued_samples[$];
  out_item_t expected_reports[$];

  int          error_count = 0;
  int          report_index = 0;
  int          stimulus_count = 0;
  int          cycle_count = 0;
  bit          item_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  ready_mode_e ready_mode = READY_ALWAYS;
  int          ready_mode_left = 0;

  // Mirror of the configuration registers, at their reset values.
  logic [1:0]                  axis_sel = 2'd0;
  logic signed [ThrWidth-1:0]  thr_cfg = 16'sd700;
  logic [LevelWidth-1:0]       margin_cfg = 15'd100;
  logic [LevelWidth-1:0]       sat_cfg = 15'd4900;

  // Detector state as the unit should hold it.
  bit                      have_baseline = 1'b0;
  bit                      running = 1'b0;
  int                      watch_axis = 0;
  int                      thr_abs = 0;
  sample_t                 base_v[AxisCount] = '{default: '0};
  sample_t                 att_v[AxisCount] = '{default: '0};
  sample_t                 ext_v[AxisCount] = '{default: '0};
  sample_t                 det_v[AxisCount] = '{default: '0};
  sample_t                 peak_hi = '0;
  sample_t                 peak_lo = '0;
  logic signed [SampleWidth:0] excursion = '0;
  bit                      closed = 1'b0;
  bit                      att_ok = 1'b0;
  bit                      det_ok = 1'b0;

  magnetic_cover_attach_detach_detector_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Arithmetic helpers
  // ---------------------------------------------------------------------------

  // Out-of-range axis codes fall onto the last axis.
  function automatic int limit_axis(logic [1:0] code);
    return (int'(code) >= AxisCount) ? AxisCount - 1 : int'(code);
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int fit_sample(int v);
    return (v > SAMPLE_MAX) ? SAMPLE_MAX : ((v < SAMPLE_MIN) ? SAMPLE_MIN : v);
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // ---------------------------------------------------------------------------
  // Detector model: advance the state by one transaction, return its report
  // ---------------------------------------------------------------------------
  function automatic out_item_t step_detector(in_item_t it);
    out_item_t rep;
    int        m[AxisCount];
    int        r;
    int        a;
    int        v;
    int        b;
    int        diff;
    int        mg;
    int        sl;
    int        i;
    bit        up;
    r  = limit_axis(it.report_axis);
    mg = margin_cfg;
    sl = sat_cfg;
    if (it.kind == KIND_RESTART) begin
      // Arm the test; the vectors stay as they are until the next sample.
      running       = 1'b1;
      have_baseline = 1'b0;
    end else if (running) begin
      m[0] = it.field_x;
      m[1] = it.field_y;
      m[2] = it.field_z;
      if (!have_baseline) begin
        // First sample after a restart: take the baseline, latch axis and threshold.
        for (i = 0; i < AxisCount; i++) begin
          ext_v[i]  = '0;
          det_v[i]  = '0;
          base_v[i] = sample_t'(m[i]);
          att_v[i]  = sample_t'(m[i]);
        end
        watch_axis    = limit_axis(axis_sel);
        thr_abs       = magnitude(int'(thr_cfg));
        peak_hi       = sample_t'(m[watch_axis]);
        peak_lo       = sample_t'(m[watch_axis]);
        excursion     = '0;
        closed        = 1'b0;
        att_ok        = 1'b0;
        det_ok        = 1'b0;
        have_baseline = 1'b1;
      end
      a = watch_axis;
      if (!closed) begin
        // Cover open: follow max and min, keep the furthest excursion.
        v = m[a];
        b = base_v[a];
        if (v > int'(peak_hi)) begin
          peak_hi = sample_t'(v);
          if (magnitude(int'(peak_hi) - b) > magnitude(int'(peak_lo) - b))
            for (i = 0; i < AxisCount; i++) att_v[i] = sample_t'(m[i]);
        end else if (v < int'(peak_lo)) begin
          peak_lo = sample_t'(v);
          if (magnitude(int'(peak_hi) - b) < magnitude(int'(peak_lo) - b))
            for (i = 0; i < AxisCount; i++) att_v[i] = sample_t'(m[i]);
        end
        excursion = v - b;
        if (magnitude(int'(excursion)) > thr_abs) begin
          closed = 1'b1;
          att_ok = 1'b1;
          for (i = 0; i < AxisCount; i++) begin
            att_v[i] = sample_t'(m[i]);
            ext_v[i] = sample_t'(m[i]);
          end
        end
      end else begin
        // Cover closed: saturation reads as the level in the attach direction.
        up = (excursion > 0);
        if (it.saturated)
          for (i = 0; i < AxisCount; i++) m[i] = up ? sl : -sl;
        if (up ? (m[a] > int'(ext_v[a])) : (m[a] < int'(ext_v[a]))) begin
          for (i = 0; i < AxisCount; i++) begin
            ext_v[i] = sample_t'(m[i]);
            det_v[i] = '0;
          end
        end
        diff = m[a] - int'(ext_v[a]);
        if (up ? (m[a] < int'(ext_v[a]) - mg) : (m[a] > int'(ext_v[a]) + mg))
          for (i = 0; i < AxisCount; i++) det_v[i] = sample_t'(m[i]);
        if (up ? (diff < -thr_abs) : (diff > thr_abs)) begin
          closed  = 1'b0;
          det_ok  = 1'b1;
          running = 1'b0;
        end
      end
    end
    rep.cover_closed   = closed;
    rep.attach_passed  = att_ok;
    rep.detach_passed  = det_ok;
    rep.test_running   = running;
    rep.baseline_value = base_v[r];
    rep.attach_value   = att_v[r];
    rep.extremum_value = ext_v[r];
    rep.detach_value   = det_v[r];
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic compare_field(string name, logic [15:0] got_v, logic [15:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                report_index, name, got_v, want_v));
  endtask

  // ---------------------------------------------------------------------------
  // Input side: record each accepted transaction at the rising edge, then
  // drive the next one at the falling edge in bursts separated by gaps.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_reports.push_back(step_detector(in_data));
      item_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      // Hold the current transaction until it is taken; only then move on.
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_samples.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= queued_samples.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // Close the burst: a quarter of the time run straight on with no gap.
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : rand_between(1, 8);
          burst_left = ($urandom_range(0, 7) == 0) ? rand_between(50, 150)
                                                   : rand_between(1, 24);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall in stretches of different character, and check every
  // accepted result against the oldest outstanding report.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode      = ready_mode_e'($urandom_range(0, 3));
      ready_mode_left = rand_between(4, 60);
    end else begin
      ready_mode_left--;
    end
    case (ready_mode)
      READY_ALWAYS: begin
        out_ready <= 1'b1;
      end
      READY_COIN: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      READY_SPARSE: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= 1'b0;
      end
    endcase
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  report_index));
      end else begin
        want = expected_reports.pop_front();
        compare_field("cover_closed",   out_data.cover_closed,   want.cover_closed);
        compare_field("attach_passed",  out_data.attach_passed,  want.attach_passed);
        compare_field("detach_passed",  out_data.detach_passed,  want.detach_passed);
        compare_field("test_running",   out_data.test_running,   want.test_running);
        compare_field("baseline_value", out_data.baseline_value, want.baseline_value);
        compare_field("attach_value",   out_data.attach_value,   want.attach_value);
        compare_field("extremum_value", out_data.extremum_value, want.extremum_value);
        compare_field("detach_value",   out_data.detach_value,   want.detach_value);
      end
      report_index++;
    end
  end

  // Watchdog: drop out if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  task automatic queue_item(bit kind, int x, int y, int z, bit sat, int rep);
    in_item_t it;
    it.kind        = kind;
    it.field_x     = sample_t'(x);
    it.field_y     = sample_t'(y);
    it.field_z     = sample_t'(z);
    it.saturated   = sat;
    it.report_axis = 2'(rep);
    queued_samples.push_back(it);
    stimulus_count++;
  endtask

  // Put a chosen value on the watched axis; the other axes carry random content.
  task automatic queue_on_axis(int w, int val, bit sat);
    int f[AxisCount];
    int i;
    for (i = 0; i < AxisCount; i++) f[i] = rand_between(SAMPLE_MIN, SAMPLE_MAX);
    f[w] = fit_sample(val);
    queue_item(KIND_SAMPLE, f[0], f[1], f[2], sat, $urandom_range(0, 3));
  endtask

  task automatic queue_restart();
    queue_item(KIND_RESTART, rand_between(SAMPLE_MIN, SAMPLE_MAX),
               rand_between(SAMPLE_MIN, SAMPLE_MAX), rand_between(SAMPLE_MIN, SAMPLE_MAX),
               1'($urandom_range(0, 1)), $urandom_range(0, 3));
  endtask

  // Unstructured transactions: stray samples, stray restarts.
  task automatic queue_noise();
    int n;
    int i;
    n = rand_between(1, 4);
    for (i = 0; i < n; i++)
      queue_item(($urandom_range(0, 3) == 0) ? KIND_RESTART : KIND_SAMPLE,
                 rand_between(SAMPLE_MIN, SAMPLE_MAX), rand_between(SAMPLE_MIN, SAMPLE_MAX),
                 rand_between(SAMPLE_MIN, SAMPLE_MAX), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 3));
  endtask

  // One factory test: restart, baseline, wander, attach, push on, pull back,
  // detach. Some runs are cut short or left without a detach.
  task automatic queue_cover_cycle();
    int w;
    int thr;
    int mg;
    int sl;
    int dir;
    int base;
    int peak;
    int n;
    int i;
    bit sat;
    w   = limit_axis(axis_sel);
    thr = magnitude(int'(thr_cfg));
    mg  = margin_cfg;
    sl  = sat_cfg;
    dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
    queue_restart();
    if ($urandom_range(0, 7) == 0)
      base = (dir > 0) ? SAMPLE_MIN : SAMPLE_MAX;
    else
      base = rand_between(-8000, 8000);
    queue_on_axis(w, base, 1'($urandom_range(0, 1)));
    n = $urandom_range(0, 5);
    for (i = 0; i < n; i++)
      queue_on_axis(w, base + rand_between(-thr, thr), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0)
      return;
    peak = fit_sample(base + dir * (thr + 1 + rand_between(0, 1500)));
    if ($urandom_range(0, 7) == 0)
      peak = (dir > 0) ? SAMPLE_MAX : SAMPLE_MIN;
    queue_on_axis(w, peak, 1'b0);
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) begin
      sat = ($urandom_range(0, 5) == 0);
      if (sat) begin
        peak = (dir > 0) ? ((sl > peak) ? sl : peak) : ((-sl < peak) ? -sl : peak);
        queue_on_axis(w, rand_between(SAMPLE_MIN, SAMPLE_MAX), 1'b1);
      end else if ($urandom_range(0, 3) == 0) begin
        // Jitter back inside the margin.
        queue_on_axis(w, peak - dir * rand_between(0, mg), 1'b0);
      end else begin
        peak = fit_sample(peak + dir * rand_between(0, 800));
        queue_on_axis(w, peak, 1'b0);
      end
    end
    queue_on_axis(w, peak - dir * (mg + 1 + rand_between(0, 200)), 1'b0);
    if ($urandom_range(0, 3) != 0)
      queue_on_axis(w, peak - dir * (thr + 1 + rand_between(0, 1500)),
                    ($urandom_range(0, 7) == 0));
    if ($urandom_range(0, 4) == 0)
      queue_on_axis(w, rand_between(SAMPLE_MIN, SAMPLE_MAX), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Configuration writes, only ever issued while the unit is idle
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataWidth-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CfgAxisChoice:   axis_sel   = val[1:0];
      CfgThreshold:    thr_cfg    = val;
      CfgDetachMargin: margin_cfg = val[LevelWidth-1:0];
      default:         sat_cfg    = val[LevelWidth-1:0];
    endcase
  endtask

  // Write all four registers; unused upper data bits carry random junk.
  task automatic apply_settings(int ax, int thr, int mg, int sl);
    write_reg(CfgAxisChoice, {14'($urandom), 2'(ax)});
    write_reg(CfgThreshold, 16'(thr));
    write_reg(CfgDetachMargin, {1'($urandom), 15'(mg)});
    write_reg(CfgSatLevel, {1'($urandom), 15'(sl)});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until the sender is idle and every outstanding report has come back,
  // then let the pipeline settle.
  task automatic wait_drained();
    while (!(queued_samples.size() == 0 && !in_valid && expected_reports.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int p;
    int phase_target;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: x axis, threshold 700, margin 100,
    // saturation level 4900.
    queue_item(KIND_SAMPLE, 32767, -32768, 0, 1'b1, 3);   // sample with no test running
    queue_item(KIND_RESTART, 0, 0, 0, 1'b0, 0);
    queue_item(KIND_SAMPLE, 100, -32768, 32767, 1'b0, 2); // baseline
    queue_item(KIND_SAMPLE, 500, 1, -1, 1'b0, 0);         // new maximum
    queue_item(KIND_SAMPLE, -300, 2, -2, 1'b1, 1);        // new minimum, equal excursion
    queue_item(KIND_SAMPLE, 801, 3, 3, 1'b0, 3);          // attach upwards, axis clamps
    queue_item(KIND_SAMPLE, 1500, -5, 7, 1'b0, 0);        // extremum grows
    queue_item(KIND_SAMPLE, 0, 0, 0, 1'b1, 1);            // saturated: plus level
    queue_item(KIND_SAMPLE, 4799, 11, -11, 1'b0, 2);      // pull-back past the margin
    queue_item(KIND_SAMPLE, 4950, 12, 12, 1'b0, 0);       // new extremum clears detach
    queue_item(KIND_SAMPLE, 4249, 13, 13, 1'b0, 1);       // detach, test ends
    queue_item(KIND_SAMPLE, -32768, 32767, -32768, 1'b1, 2);
    queue_item(KIND_RESTART, 1, 1, 1, 1'b1, 3);
    queue_item(KIND_RESTART, -1, -1, -1, 1'b0, 1);        // back-to-back restarts
    queue_item(KIND_SAMPLE, 0, -1, 1, 1'b0, 0);           // baseline
    queue_item(KIND_SAMPLE, -701, 0, 0, 1'b0, 0);         // attach downwards
    queue_item(KIND_SAMPLE, 0, 0, 0, 1'b1, 0);            // saturated: minus level
    queue_item(KIND_SAMPLE, -4700, 0, 0, 1'b0, 2);        // pull-back past the margin
    queue_item(KIND_RESTART, 0, 0, 0, 1'b0, 1);           // restart while closed
    queue_item(KIND_SAMPLE, -32768, 0, 0, 1'b0, 0);       // baseline at the floor
    queue_item(KIND_SAMPLE, 32767, -32768, 32767, 1'b0, 1); // full-scale attach
    queue_item(KIND_SAMPLE, -32768, 32767, -32768, 1'b0, 0); // full-scale detach
    wait_drained();

    // Random part: a spread of settings, extremes first, then random ones.
    for (p = 0; p < SETTING_COUNT; p++) begin
      case (p)
        0: apply_settings(1, -1200, 50, 32767);
        1: apply_settings(3, -32768, 0, 0);             // most negative threshold
        2: apply_settings(0, 0, 32767, 4900);
        3: apply_settings(2, 32767, rand_between(0, 32767), rand_between(0, 32767));
        default: apply_settings($urandom_range(0, 3), rand_between(-3000, 3000),
                                rand_between(0, 1500), rand_between(0, 32767));
      endcase
      phase_target = stimulus_count + PHASE_ITEMS;
      while (stimulus_count < phase_target) begin
        if ($urandom_range(0, 5) == 0)
          queue_noise();
        else
          queue_cover_cycle();
      end
      wait_drained();
    end

    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
